FILE: hw/rtl/pointer_gesture_classifier_macros.svh
// Assertion macros used by the checker of the pointer gesture classifier.
`ifndef POINTER_GESTURE_CLASSIFIER_MACROS_SVH
`define POINTER_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define PGC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication.
`define PGC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/pgc_pkg.sv
`timescale 1ns / 1ps

package pgc_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned MOVE_W     = 17;
  localparam int unsigned WHEEL_W    = 17;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned ACCUM_W    = 32;
  localparam int unsigned VP_W       = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TICK_W-1:0] CLICK_WINDOW_RESET = 16'd400;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW    = 3'd4;

  typedef enum logic [2:0] {
    GEST_NONE       = 3'd0,
    GEST_LEFT_DOWN  = 3'd1,
    GEST_LEFT_DRAG  = 3'd2,
    GEST_DRAG_UP    = 3'd3,
    GEST_CLICK      = 3'd4,
    GEST_DBL_CLICK  = 3'd5
  } gesture_t;

endpackage

FILE: hw/rtl/pgc_ifs.sv
`timescale 1ns / 1ps

interface pgc_in_if;
  import pgc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [TICK_W-1:0]          elapsed_ticks;
  logic signed [COORD_W-1:0]  cursor_x;
  logic signed [COORD_W-1:0]  cursor_y;
  logic                       left_level;
  logic                       right_level;
  logic                       middle_level;
  logic [TICK_W-1:0]          wheel_raw;

  modport source (output valid, elapsed_ticks, cursor_x, cursor_y, left_level,
                  right_level, middle_level, wheel_raw, input ready);
  modport sink (input valid, elapsed_ticks, cursor_x, cursor_y, left_level,
                right_level, middle_level, wheel_raw, output ready);
endinterface

interface pgc_out_if;
  import pgc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [MOVE_W-1:0]   move_x;
  logic signed [MOVE_W-1:0]   move_y;
  logic signed [WHEEL_W-1:0]  wheel;
  gesture_t                   gesture;
  logic                       left_click;
  logic                       right_click;
  logic                       right_release;
  logic                       middle_release;
  logic                       inside_res;

  modport source (output valid, pos_x, pos_y, move_x, move_y, wheel, gesture,
                  left_click, right_click, right_release, middle_release,
                  inside_res, input ready);
  modport sink (input valid, pos_x, pos_y, move_x, move_y, wheel, gesture,
                left_click, right_click, right_release, middle_release,
                inside_res, output ready);
endinterface

interface pgc_cfg_if;
  import pgc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/pointer_gesture_classifier.sv
`timescale 1ns / 1ps
// An accepted request has its result in the output register in the next cycle.
// Throughput: 1 request per cycle; the output register is the only stage, and
// a new request is taken whenever the result register is empty or being drained.
// Reset (rst, synchronous): viewport 0, click window 400, all tracking state
// cleared, output empty.

module pointer_gesture_classifier (
  input  logic       clk,
  input  logic       rst,
  pgc_in_if.sink     in_chan,
  pgc_out_if.source  out_chan,
  pgc_cfg_if.sink    cfg_chan
);
  import pgc_pkg::*;

  // configuration
  logic [VP_W-1:0]   vp_left;
  logic [VP_W-1:0]   vp_top;
  logic [VP_W-1:0]   vp_width;
  logic [VP_W-1:0]   vp_height;
  logic [TICK_W-1:0] click_window;

  // tracking state
  logic [ACCUM_W-1:0]  tick_accum;
  logic                first_click_pending;
  logic                left_down;
  logic                right_down;
  logic                middle_down;
  logic [2*COORD_W-1:0] left_press_point;
  logic [2*COORD_W-1:0] right_press_point;
  logic [2*COORD_W-1:0] last_position;
  gesture_t            last_gesture;
  logic                left_flag;
  logic                right_flag;

  logic                out_valid;
  logic                accept;

  // next values
  logic [ACCUM_W-1:0]   tick_accum_next;
  logic                 first_click_pending_next;
  logic                 left_down_next;
  logic                 right_down_next;
  logic                 middle_down_next;
  logic [2*COORD_W-1:0] left_press_point_next;
  logic [2*COORD_W-1:0] right_press_point_next;
  gesture_t             last_gesture_next;
  logic                 left_flag_next;
  logic                 right_flag_next;

  logic [ACCUM_W:0]      acc_sum;
  logic [ACCUM_W-1:0]    acc_sat;
  logic                  pend_live;
  logic signed [17:0]    x0, x1, x2, y0, y1, y2;
  logic signed [17:0]    vl_s, vt_s, x_edge, y_edge;
  logic                  outside;
  logic [2*COORD_W-1:0]  pos;
  logic signed [MOVE_W-1:0] move_x_c, move_y_c;
  logic signed [WHEEL_W-1:0] wheel_c;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !out_valid || out_chan.ready;
  assign accept         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid;

  // saturating tick counter and click expiry
  assign acc_sum   = {1'b0, tick_accum} + {{(ACCUM_W-TICK_W+1){1'b0}}, in_chan.elapsed_ticks};
  assign acc_sat   = acc_sum[ACCUM_W] ? {ACCUM_W{1'b1}} : acc_sum[ACCUM_W-1:0];
  assign pend_live = first_click_pending &&
                     (acc_sat < {{(ACCUM_W-TICK_W){1'b0}}, click_window});

  // viewport clamp: left, top, right, bottom in turn
  assign vl_s   = $signed({4'b0, vp_left});
  assign vt_s   = $signed({4'b0, vp_top});
  assign x_edge = vl_s + $signed({4'b0, vp_width});
  assign y_edge = vt_s + $signed({4'b0, vp_height});
  assign x0     = {{2{in_chan.cursor_x[15]}}, in_chan.cursor_x};
  assign y0     = {{2{in_chan.cursor_y[15]}}, in_chan.cursor_y};
  assign x1     = (x0 < vl_s) ? vl_s : x0;
  assign y1     = (y0 < vt_s) ? vt_s : y0;
  assign x2     = (x1 >= x_edge) ? x_edge - 18'sd1 : x1;
  assign y2     = (y1 >= y_edge) ? y_edge - 18'sd1 : y1;
  assign outside = (x0 < vl_s) || (y0 < vt_s) || (x1 >= x_edge) || (y1 >= y_edge);
  assign pos    = {y2[15:0], x2[15:0]};

  assign move_x_c = $signed({x2[15], x2[15:0]}) -
                    $signed({last_position[15], last_position[15:0]});
  assign move_y_c = $signed({y2[15], y2[15:0]}) -
                    $signed({last_position[31], last_position[31:16]});

  // raw above 32768 reads as raw - 65536
  assign wheel_c = (in_chan.wheel_raw > 16'd32768) ? $signed({1'b1, in_chan.wheel_raw})
                                                   : $signed({1'b0, in_chan.wheel_raw});

  always_comb begin
    tick_accum_next          = acc_sat;
    first_click_pending_next = pend_live;
    left_down_next           = left_down;
    right_down_next          = right_down;
    middle_down_next         = middle_down;
    left_press_point_next    = left_press_point;
    right_press_point_next   = right_press_point;
    last_gesture_next        = last_gesture;
    left_flag_next           = left_flag;
    right_flag_next          = right_flag;
    if (!outside) begin
      left_flag_next   = 1'b0;
      right_flag_next  = 1'b0;
      middle_down_next = in_chan.middle_level;
      if (in_chan.left_level) begin
        last_gesture_next = GEST_LEFT_DOWN;
        if (!left_down) begin
          left_down_next        = 1'b1;
          left_press_point_next = pos;
        end else if (left_press_point != pos) begin
          last_gesture_next = GEST_LEFT_DRAG;
        end
        if (!pend_live) begin
          tick_accum_next = '0;
        end
      end else if (left_down) begin
        left_down_next = 1'b0;
        if (!pend_live) begin
          first_click_pending_next = 1'b1;
          if (last_gesture == GEST_LEFT_DRAG) begin
            last_gesture_next = GEST_DRAG_UP;
          end else begin
            last_gesture_next = GEST_CLICK;
            left_flag_next    = 1'b1;
          end
        end else begin
          if (left_press_point == pos) begin
            last_gesture_next = GEST_DBL_CLICK;
          end
          first_click_pending_next = 1'b0;
        end
      end else begin
        // left idle: follow the right button
        if (in_chan.right_level) begin
          if (!right_down) begin
            right_down_next        = 1'b1;
            right_press_point_next = pos;
          end
        end else begin
          right_flag_next = right_down && (right_press_point == pos);
          right_down_next = 1'b0;
        end
        last_gesture_next = GEST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_left             <= '0;
      vp_top              <= '0;
      vp_width            <= '0;
      vp_height           <= '0;
      click_window        <= CLICK_WINDOW_RESET;
      tick_accum          <= '0;
      first_click_pending <= 1'b0;
      left_down           <= 1'b0;
      right_down          <= 1'b0;
      middle_down         <= 1'b0;
      left_press_point    <= '0;
      right_press_point   <= '0;
      last_position       <= '0;
      last_gesture        <= GEST_NONE;
      left_flag           <= 1'b0;
      right_flag          <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          CFG_VIEWPORT_LEFT:   vp_left      <= cfg_chan.data[VP_W-1:0];
          CFG_VIEWPORT_TOP:    vp_top       <= cfg_chan.data[VP_W-1:0];
          CFG_VIEWPORT_WIDTH:  vp_width     <= cfg_chan.data[VP_W-1:0];
          CFG_VIEWPORT_HEIGHT: vp_height    <= cfg_chan.data[VP_W-1:0];
          CFG_CLICK_WINDOW:    click_window <= cfg_chan.data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        tick_accum          <= tick_accum_next;
        first_click_pending <= first_click_pending_next;
        left_down           <= left_down_next;
        right_down          <= right_down_next;
        middle_down         <= middle_down_next;
        left_press_point    <= left_press_point_next;
        right_press_point   <= right_press_point_next;
        last_position       <= pos;
        last_gesture        <= last_gesture_next;
        left_flag           <= left_flag_next;
        right_flag          <= right_flag_next;
        out_valid           <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_chan.pos_x          <= $signed(x2[15:0]);
      out_chan.pos_y          <= $signed(y2[15:0]);
      out_chan.move_x         <= move_x_c;
      out_chan.move_y         <= move_y_c;
      out_chan.wheel          <= wheel_c;
      out_chan.gesture        <= last_gesture_next;
      out_chan.left_click     <= left_flag_next;
      out_chan.right_click    <= right_flag_next;
      out_chan.right_release  <= right_down && !right_down_next;
      out_chan.middle_release <= middle_down && !middle_down_next;
      out_chan.inside_res     <= !outside;
    end
  end

endmodule

FILE: hw/rtl/pgc_checker.sv
`timescale 1ns / 1ps
`include "pointer_gesture_classifier_macros.svh"

module pgc_assert_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input pgc_pkg::gesture_t     gesture,
  input logic                  left_click,
  input logic                  right_click,
  input logic                  right_release,
  input logic                  middle_release,
  input logic                  inside_res
);
  import pgc_pkg::*;

  `PGC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PGC_ASSERT_NEXT(a_req_result, clk, rst, in_valid && in_ready, out_valid)
  `PGC_ASSERT_IMP(a_outside_no_release, clk, rst, out_valid && !inside_res, !right_release && !middle_release)
  `PGC_ASSERT_IMP(a_left_click_gesture, clk, rst, out_valid && left_click, gesture == GEST_CLICK)
  `PGC_ASSERT_IMP(a_right_click_idle, clk, rst, out_valid && right_click, gesture == GEST_NONE)

endmodule

bind pointer_gesture_classifier pgc_assert_checker u_pgc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .gesture        (out_chan.gesture),
  .left_click     (out_chan.left_click),
  .right_click    (out_chan.right_click),
  .right_release  (out_chan.right_release),
  .middle_release (out_chan.middle_release),
  .inside_res     (out_chan.inside_res)
);
